### hw/rtl/gn2_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the 2D gradient noise core.
// No dependencies; every other file in hw/rtl uses it by scoped name.
package gn2_pkg;

  localparam int GRID_SIZE_DEF = 16;
  localparam int FRAC_BITS_DEF = 8;

  localparam int CELL_W   = 4;
  localparam int GRAD_W   = 16;
  localparam int POS_W    = 12;
  localparam int NOISE_W  = 16;
  localparam int ENTRY_W  = 2 * GRAD_W;
  localparam int CORNER_W = 18;

  // Compare-subtract steps that bring an integer part below the grid size
  localparam int RED_STEPS = 8;

  localparam int PIPE_DEPTH = 8;

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_EVAL  = 1'b1
  } cmd_t;

endpackage

### hw/rtl/gradient_noise_2d_core.sv
`timescale 1ns / 1ps
// Top level of the 2D gradient noise core.
// Depends on gn2_pkg, gn2_mem, gn2_dot and gn2_lerp.
//
// Usage:
//   Drive an item on the in_ ports and raise start; it is taken at any rising
//   edge where start is high and busy is low. busy is high during reset and
//   until an edge with rst_n high, then low; one item can be taken each cycle.
//   A write item (in_command = CMD_WRITE) stores grad_x/grad_y at cell
//   (cell_col, cell_row) and gives no result. An evaluate item gives one
//   noise value from pos_x/pos_y.
//   Results appear on out_noise_value for one cycle with out_valid high,
//   in order, after the table read, dot product, interpolation and output
//   registers; the receiver cannot stall.
//   Throughput is one item per cycle: two copies of the table, each with two
//   read ports, supply the four corner gradients, read at the edge that takes
//   the item; dot products and interpolations run as a multiplier pipeline.
//   A write is visible to an evaluate taken in the very next cycle.
//   Reset clears the pipeline valid bits and holds busy high; the table is
//   not cleared, so every cell must be written before it is read.
module gradient_noise_2d_core #(
  parameter int GRID_SIZE = gn2_pkg::GRID_SIZE_DEF,
  parameter int FRAC_BITS = gn2_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic                               in_command,
  input  logic [gn2_pkg::CELL_W-1:0]         in_cell_col,
  input  logic [gn2_pkg::CELL_W-1:0]         in_cell_row,
  input  logic signed [gn2_pkg::GRAD_W-1:0]  in_grad_x,
  input  logic signed [gn2_pkg::GRAD_W-1:0]  in_grad_y,
  input  logic [gn2_pkg::POS_W-1:0]          in_pos_x,
  input  logic [gn2_pkg::POS_W-1:0]          in_pos_y,
  output logic                               out_valid,
  output logic signed [gn2_pkg::NOISE_W-1:0] out_noise_value
);

  localparam int DEPTH = GRID_SIZE * GRID_SIZE;
  localparam int AW    = $clog2(DEPTH);
  localparam int IW    = $clog2(GRID_SIZE);
  localparam int XW    = gn2_pkg::POS_W + FRAC_BITS;
  localparam int CW    = gn2_pkg::CORNER_W;
  localparam int ND    = gn2_pkg::PIPE_DEPTH;
  localparam logic signed [CW-1:0] SAT_HI = CW'(32767);
  localparam logic signed [CW-1:0] SAT_LO = -CW'(32768);

  function automatic logic [IW-1:0] wrap_idx(input logic [gn2_pkg::POS_W-1:0] v);
    int r;
    r = int'(v);
    for (int k = gn2_pkg::RED_STEPS - 1; k >= 0; k--) begin
      if (r >= (GRID_SIZE << k)) begin
        r = r - (GRID_SIZE << k);
      end
    end
    return IW'(r);
  endfunction

  function automatic logic [IW-1:0] next_idx(input logic [IW-1:0] i);
    return (i == IW'(GRID_SIZE - 1)) ? '0 : i + 1'b1;
  endfunction

  function automatic logic [AW-1:0] addr_of(input logic [IW-1:0] col,
                                            input logic [IW-1:0] row);
    return AW'(AW'(col) * AW'(GRID_SIZE)) + AW'(row);
  endfunction

  logic                   busy_r;
  logic                   accept;
  logic                   wr_en;
  logic [AW-1:0]          wr_addr;
  logic [gn2_pkg::ENTRY_W-1:0] wr_data;
  logic [XW-1:0]          px_w;
  logic [XW-1:0]          py_w;
  logic [IW-1:0]          col0;
  logic [IW-1:0]          col1;
  logic [IW-1:0]          row0;
  logic [IW-1:0]          row1;
  logic [ND-1:0]          valid_r;
  logic [FRAC_BITS-1:0]   fx_d_r [5];
  logic [FRAC_BITS-1:0]   fy_d_r [3];
  logic [gn2_pkg::ENTRY_W-1:0] e00;
  logic [gn2_pkg::ENTRY_W-1:0] e01;
  logic [gn2_pkg::ENTRY_W-1:0] e10;
  logic [gn2_pkg::ENTRY_W-1:0] e11;
  logic signed [FRAC_BITS:0] dx_near;
  logic signed [FRAC_BITS:0] dx_far;
  logic signed [FRAC_BITS:0] dy_near;
  logic signed [FRAC_BITS:0] dy_far;
  logic signed [CW-1:0]   c00_r;
  logic signed [CW-1:0]   c01_r;
  logic signed [CW-1:0]   c10_r;
  logic signed [CW-1:0]   c11_r;
  logic signed [CW-1:0]   colv0_r;
  logic signed [CW-1:0]   colv1_r;
  logic signed [CW-1:0]   mix_r;
  logic signed [gn2_pkg::NOISE_W-1:0] noise_nxt;
  logic signed [gn2_pkg::NOISE_W-1:0] noise_r;

  assign busy   = busy_r;
  assign accept = start && !busy_r;
  assign wr_en  = accept && (in_command == gn2_pkg::CMD_WRITE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b1;
      valid_r <= '0;
    end else begin
      busy_r  <= 1'b0;
      valid_r <= {valid_r[ND-2:0], accept && (in_command == gn2_pkg::CMD_EVAL)};
    end
  end

  assign wr_addr = addr_of(wrap_idx(gn2_pkg::POS_W'(in_cell_col)),
                           wrap_idx(gn2_pkg::POS_W'(in_cell_row)));
  assign wr_data = {in_grad_y, in_grad_x};

  // split point into cell and fraction
  assign px_w = XW'(in_pos_x);
  assign py_w = XW'(in_pos_y);
  assign col0 = wrap_idx(px_w[XW-1:FRAC_BITS]);
  assign row0 = wrap_idx(py_w[XW-1:FRAC_BITS]);
  assign col1 = next_idx(col0);
  assign row1 = next_idx(row0);

  gn2_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem_near (
    .clk         (clk),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .wr_data     (wr_data),
    .rd_addr_a   (addr_of(col0, row0)),
    .rd_addr_b   (addr_of(col0, row1)),
    .rd_data_a_r (e00),
    .rd_data_b_r (e01)
  );

  gn2_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem_far (
    .clk         (clk),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .wr_data     (wr_data),
    .rd_addr_a   (addr_of(col1, row0)),
    .rd_addr_b   (addr_of(col1, row1)),
    .rd_data_a_r (e10),
    .rd_data_b_r (e11)
  );

  always_ff @(posedge clk) begin
    fx_d_r[0] <= px_w[FRAC_BITS-1:0];
    fy_d_r[0] <= py_w[FRAC_BITS-1:0];
    for (int i = 1; i < 5; i++) begin
      fx_d_r[i] <= fx_d_r[i-1];
    end
    for (int i = 1; i < 3; i++) begin
      fy_d_r[i] <= fy_d_r[i-1];
    end
  end

  // far offsets are fraction minus one
  assign dx_near = {1'b0, fx_d_r[0]};
  assign dx_far  = {1'b1, fx_d_r[0]};
  assign dy_near = {1'b0, fy_d_r[0]};
  assign dy_far  = {1'b1, fy_d_r[0]};

  gn2_dot #(.FRAC_BITS(FRAC_BITS)) u_dot00 (
    .clk(clk), .entry(e00), .dx(dx_near), .dy(dy_near), .dot_r(c00_r));
  gn2_dot #(.FRAC_BITS(FRAC_BITS)) u_dot01 (
    .clk(clk), .entry(e01), .dx(dx_near), .dy(dy_far), .dot_r(c01_r));
  gn2_dot #(.FRAC_BITS(FRAC_BITS)) u_dot10 (
    .clk(clk), .entry(e10), .dx(dx_far), .dy(dy_near), .dot_r(c10_r));
  gn2_dot #(.FRAC_BITS(FRAC_BITS)) u_dot11 (
    .clk(clk), .entry(e11), .dx(dx_far), .dy(dy_far), .dot_r(c11_r));

  gn2_lerp #(.FRAC_BITS(FRAC_BITS)) u_lerp_col0 (
    .clk(clk), .a(c00_r), .b(c01_r), .t(fy_d_r[2]), .res_r(colv0_r));
  gn2_lerp #(.FRAC_BITS(FRAC_BITS)) u_lerp_col1 (
    .clk(clk), .a(c10_r), .b(c11_r), .t(fy_d_r[2]), .res_r(colv1_r));
  gn2_lerp #(.FRAC_BITS(FRAC_BITS)) u_lerp_row (
    .clk(clk), .a(colv0_r), .b(colv1_r), .t(fx_d_r[4]), .res_r(mix_r));

  always_comb begin
    if (mix_r > SAT_HI) begin
      noise_nxt = gn2_pkg::NOISE_W'(SAT_HI);
    end else if (mix_r < SAT_LO) begin
      noise_nxt = gn2_pkg::NOISE_W'(SAT_LO);
    end else begin
      noise_nxt = gn2_pkg::NOISE_W'(mix_r);
    end
  end

  always_ff @(posedge clk) begin
    noise_r <= noise_nxt;
  end

  assign out_valid       = valid_r[ND-1];
  assign out_noise_value = noise_r;

endmodule

### hw/rtl/gn2_mem.sv
`timescale 1ns / 1ps
// Gradient table storage: one write port, two registered read ports.
// Uses gn2_pkg for the entry width.
module gn2_mem #(
  parameter int DEPTH = gn2_pkg::GRID_SIZE_DEF * gn2_pkg::GRID_SIZE_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                         clk,
  input  logic                         wr_en,
  input  logic [AW-1:0]                wr_addr,
  input  logic [gn2_pkg::ENTRY_W-1:0]  wr_data,
  input  logic [AW-1:0]                rd_addr_a,
  input  logic [AW-1:0]                rd_addr_b,
  output logic [gn2_pkg::ENTRY_W-1:0]  rd_data_a_r,
  output logic [gn2_pkg::ENTRY_W-1:0]  rd_data_b_r
);

  logic [gn2_pkg::ENTRY_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_a_r <= mem[rd_addr_a];
    rd_data_b_r <= mem[rd_addr_b];
  end

endmodule

### hw/rtl/gn2_dot.sv
`timescale 1ns / 1ps
// Corner dot product: gradient times offset, two stages, rounded to Q3.14.
// Uses gn2_pkg for field widths.
module gn2_dot #(
  parameter int FRAC_BITS = gn2_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic [gn2_pkg::ENTRY_W-1:0]         entry,
  input  logic signed [FRAC_BITS:0]           dx,
  input  logic signed [FRAC_BITS:0]           dy,
  output logic signed [gn2_pkg::CORNER_W-1:0] dot_r
);

  localparam int PW = gn2_pkg::GRAD_W + FRAC_BITS + 1;
  localparam int SW = PW + 1;

  logic signed [gn2_pkg::GRAD_W-1:0] gx;
  logic signed [gn2_pkg::GRAD_W-1:0] gy;
  logic signed [PW-1:0]              prod_x_r;
  logic signed [PW-1:0]              prod_y_r;
  logic signed [SW-1:0]              sum;
  logic signed [SW-1:0]              rnd;
  logic signed [SW-1:0]              shifted;

  assign gx = entry[gn2_pkg::GRAD_W-1:0];
  assign gy = entry[gn2_pkg::ENTRY_W-1:gn2_pkg::GRAD_W];

  always_ff @(posedge clk) begin
    prod_x_r <= gx * dx;
    prod_y_r <= gy * dy;
  end

  // round half up, floor shift
  assign sum     = SW'(prod_x_r) + SW'(prod_y_r);
  assign rnd     = sum + (SW'(1) <<< (FRAC_BITS - 1));
  assign shifted = rnd >>> FRAC_BITS;

  always_ff @(posedge clk) begin
    dot_r <= gn2_pkg::CORNER_W'(shifted);
  end

endmodule

### hw/rtl/gn2_lerp.sv
`timescale 1ns / 1ps
// Linear interpolation a + round(t * (b - a)), two stages.
// Uses gn2_pkg for the value width.
module gn2_lerp #(
  parameter int FRAC_BITS = gn2_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic signed [gn2_pkg::CORNER_W-1:0] a,
  input  logic signed [gn2_pkg::CORNER_W-1:0] b,
  input  logic [FRAC_BITS-1:0]                t,
  output logic signed [gn2_pkg::CORNER_W-1:0] res_r
);

  localparam int W  = gn2_pkg::CORNER_W;
  localparam int PW = W + FRAC_BITS + 2;

  logic signed [W:0]         diff;
  logic signed [FRAC_BITS:0] t_s;
  logic signed [PW-1:0]      prod_r;
  logic signed [W-1:0]       a_r;
  logic signed [PW-1:0]      rnd;
  logic signed [PW-1:0]      step;
  logic signed [W+1:0]       sum;

  assign diff = (W+1)'(b) - (W+1)'(a);
  assign t_s  = {1'b0, t};

  always_ff @(posedge clk) begin
    prod_r <= diff * t_s;
    a_r    <= a;
  end

  assign rnd  = prod_r + (PW'(1) <<< (FRAC_BITS - 1));
  assign step = rnd >>> FRAC_BITS;
  assign sum  = (W+2)'(a_r) + (W+2)'(step);

  always_ff @(posedge clk) begin
    res_r <= W'(sum);
  end

endmodule

### hw/rtl/gn2_checker.sv
`timescale 1ns / 1ps
// Port-level checks for gradient_noise_2d_core, bound to the top level.
// Uses gn2_pkg for command codes.
module gn2_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               start,
  input logic                               busy,
  input logic                               in_command,
  input logic                               out_valid,
  input logic signed [gn2_pkg::NOISE_W-1:0] out_noise_value
);

  logic take_eval;
  logic take_write;

  assign take_eval  = start && !busy && (in_command == gn2_pkg::CMD_EVAL);
  assign take_write = start && !busy && (in_command == gn2_pkg::CMD_WRITE);

  a_eval_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    take_eval |-> ##8 out_valid)
    else $error("evaluate item gave no result");

  a_write_is_silent: assert property (@(posedge clk) disable iff (!rst_n)
    take_write |-> ##8 !out_valid)
    else $error("write item gave a result");

  a_busy_in_reset: assert property (@(posedge clk)
    !rst_n |=> busy)
    else $error("busy low after reset cycle");

  a_quiet_after_reset: assert property (@(posedge clk)
    $rose(rst_n) |-> !out_valid)
    else $error("result straight after reset");

  a_result_known: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !$isunknown(out_noise_value))
    else $error("result carries unknown bits");

endmodule

bind gradient_noise_2d_core gn2_checker u_gn2_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .in_command      (in_command),
  .out_valid       (out_valid),
  .out_noise_value (out_noise_value)
);
